/* hdl/cumulative_frequency_model_macros.svh */
// ---------------------------------------------------------------------------
// Cumulative frequency model - assertion macros
// Concurrent checks on the rising clock edge, disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef CUMULATIVE_FREQUENCY_MODEL_MACROS_SVH
`define CUMULATIVE_FREQUENCY_MODEL_MACROS_SVH

// same-cycle implication
`define CFM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/cfm_pkg.sv */
// ---------------------------------------------------------------------------
// Cumulative frequency model - package
// Field widths, operation and status codes, result record.
// ---------------------------------------------------------------------------
package cfm_pkg;

  localparam int MAX_SYMBOLS_DEF = 256;
  localparam int MAX_TOTAL_DEF   = 65536;

  localparam int OP_W     = 2;
  localparam int FREQ_W   = 17;
  localparam int SYM_W    = 8;
  localparam int TARGET_W = 17;
  localparam int STAT_W   = 2;
  localparam int VAL_W    = 17;
  localparam int ALPH_W   = 9;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 72;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_RANGE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECT    = 2'd1;
  localparam logic [STAT_W-1:0] ST_QUERY_ERR = 2'd2;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SYM_W-1:0]  found_symbol;
    logic [VAL_W-1:0]  range_low;
    logic [VAL_W-1:0]  range_high;
    logic [VAL_W-1:0]  total_count;
    logic [ALPH_W-1:0] alphabet_count;
  } cfm_res_t;

endpackage

/* hdl/cfm_table.sv */
// ---------------------------------------------------------------------------
// Cumulative frequency model - cumulative table
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module cfm_table #(
  parameter int DEPTH = cfm_pkg::MAX_SYMBOLS_DEF,
  parameter int AW    = $clog2(cfm_pkg::MAX_SYMBOLS_DEF),
  parameter int DW    = $clog2(cfm_pkg::MAX_TOTAL_DEF + 1)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata_r
);

  logic [DW-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

/* hdl/cfm_ctrl.sv */
// ---------------------------------------------------------------------------
// Cumulative frequency model - sequencer
// Load accumulation, range lookup and binary search over the table.
// ---------------------------------------------------------------------------
module cfm_ctrl #(
  parameter int MAX_SYMBOLS = cfm_pkg::MAX_SYMBOLS_DEF,
  parameter int MAX_TOTAL   = cfm_pkg::MAX_TOTAL_DEF,
  parameter int AW          = $clog2(cfm_pkg::MAX_SYMBOLS_DEF),
  parameter int CNT_W       = $clog2(cfm_pkg::MAX_SYMBOLS_DEF + 1),
  parameter int SUM_W       = $clog2(cfm_pkg::MAX_TOTAL_DEF + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cfm_pkg::OP_W-1:0]      in_operation,
  input  logic [cfm_pkg::FREQ_W-1:0]    in_freq,
  input  logic                          in_last,
  input  logic [cfm_pkg::SYM_W-1:0]     in_symbol,
  input  logic [cfm_pkg::TARGET_W-1:0]  in_target,
  output logic                          res_valid,
  input  logic                          res_ready,
  output cfm_pkg::cfm_res_t             res,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [SUM_W-1:0]              mem_wdata,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [SUM_W-1:0]              mem_rdata
);

  import cfm_pkg::*;

  localparam int ACC_W = $clog2(MAX_TOTAL + (1 << FREQ_W));
  localparam int CMP_W = (CNT_W > SYM_W) ? CNT_W : SYM_W;
  localparam int TV_W  = (SUM_W > TARGET_W) ? SUM_W : TARGET_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOW  = 5'b00010,
    S_SRCH = 5'b00100,
    S_HI   = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    model_size_r, model_size_nxt;
  logic [SUM_W-1:0]    total_r, total_nxt;
  logic [CNT_W-1:0]    load_cnt_r, load_cnt_nxt;
  logic [ACC_W-1:0]    load_sum_r, load_sum_nxt;
  logic                load_active_r, load_active_nxt;
  logic                load_bad_r, load_bad_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt;
  logic [CNT_W-1:0]    hi_r, hi_nxt;
  logic [CNT_W-1:0]    mid_r, mid_nxt;
  logic [SUM_W-1:0]    lo_val_r, lo_val_nxt;
  logic                find_r, find_nxt;
  logic [TARGET_W-1:0] target_r, target_nxt;
  cfm_res_t            res_r, res_nxt;

  always_comb begin
    logic [CNT_W-1:0] cnt_v;
    logic [ACC_W-1:0] sum_v;
    logic             bad_v;
    logic [CNT_W-1:0] idx_v;
    logic [CNT_W-1:0] lo_v;
    logic [CNT_W-1:0] hi_v;
    logic [CNT_W-1:0] mid_v;
    cfm_res_t         err_v;

    state_nxt       = state_r;
    model_size_nxt  = model_size_r;
    total_nxt       = total_r;
    load_cnt_nxt    = load_cnt_r;
    load_sum_nxt    = load_sum_r;
    load_active_nxt = load_active_r;
    load_bad_nxt    = load_bad_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    mid_nxt         = mid_r;
    lo_val_nxt      = lo_val_r;
    find_nxt        = find_r;
    target_nxt      = target_r;
    res_nxt         = res_r;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '0;
    mem_raddr       = '0;

    cnt_v = '0;
    sum_v = '0;
    bad_v = 1'b0;
    idx_v = '0;
    lo_v  = '0;
    hi_v  = '0;
    mid_v = '0;

    err_v                = '0;
    err_v.status         = ST_QUERY_ERR;
    err_v.total_count    = VAL_W'(total_r);
    err_v.alphabet_count = ALPH_W'(model_size_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_operation)
            OP_LOAD: begin
              cnt_v = load_active_r ? load_cnt_r : '0;
              sum_v = load_active_r ? load_sum_r : '0;
              bad_v = load_active_r ? load_bad_r : 1'b0;
              if (!load_active_r) begin
                model_size_nxt = '0;
                total_nxt      = '0;
              end
              if (!bad_v) begin
                if (cnt_v >= CNT_W'(MAX_SYMBOLS)) begin
                  bad_v = 1'b1;
                end else begin
                  sum_v = sum_v + ACC_W'(in_freq);
                  if (sum_v > ACC_W'(MAX_TOTAL)) begin
                    bad_v = 1'b1;
                  end else begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_v[AW-1:0];
                    mem_wdata = sum_v[SUM_W-1:0];
                    cnt_v     = cnt_v + CNT_W'(1);
                  end
                end
              end
              res_nxt        = '0;
              res_nxt.status = ST_OK;
              if (!in_last) begin
                load_active_nxt = 1'b1;
              end else begin
                load_active_nxt = 1'b0;
                if (bad_v || (sum_v == '0) || (cnt_v == '0)) begin
                  model_size_nxt = '0;
                  total_nxt      = '0;
                  res_nxt.status = ST_REJECT;
                end else begin
                  model_size_nxt         = cnt_v;
                  total_nxt              = sum_v[SUM_W-1:0];
                  res_nxt.total_count    = VAL_W'(sum_v[SUM_W-1:0]);
                  res_nxt.alphabet_count = ALPH_W'(cnt_v);
                end
              end
              load_cnt_nxt = cnt_v;
              load_sum_nxt = sum_v;
              load_bad_nxt = bad_v;
              state_nxt    = S_DONE;
            end
            OP_RANGE: begin
              if (CMP_W'(in_symbol) >= CMP_W'(model_size_r)) begin
                res_nxt   = err_v;
                state_nxt = S_DONE;
              end else begin
                idx_v      = CNT_W'(in_symbol);
                lo_nxt     = idx_v;
                find_nxt   = 1'b0;
                lo_val_nxt = '0;
                if (in_symbol == '0) begin
                  mem_raddr = '0;
                  state_nxt = S_HI;
                end else begin
                  idx_v     = idx_v - CNT_W'(1);
                  mem_raddr = idx_v[AW-1:0];
                  state_nxt = S_LOW;
                end
              end
            end
            OP_FIND: begin
              if ((model_size_r == '0) || (TV_W'(in_target) >= TV_W'(total_r))) begin
                res_nxt   = err_v;
                state_nxt = S_DONE;
              end else begin
                lo_nxt     = '0;
                hi_nxt     = model_size_r;
                lo_val_nxt = '0;
                find_nxt   = 1'b1;
                target_nxt = in_target;
                if (model_size_r > CNT_W'(1)) begin
                  mid_v     = model_size_r >> 1;
                  mid_nxt   = mid_v;
                  idx_v     = mid_v - CNT_W'(1);
                  mem_raddr = idx_v[AW-1:0];
                  state_nxt = S_SRCH;
                end else begin
                  mem_raddr = '0;
                  state_nxt = S_HI;
                end
              end
            end
            default: begin
              res_nxt   = err_v;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_LOW: begin
        lo_val_nxt = mem_rdata;
        mem_raddr  = lo_r[AW-1:0];
        state_nxt  = S_HI;
      end
      S_SRCH: begin
        lo_v = lo_r;
        hi_v = hi_r;
        if (TV_W'(mem_rdata) <= TV_W'(target_r)) begin
          lo_v       = mid_r;
          lo_val_nxt = mem_rdata;
        end else begin
          hi_v = mid_r;
        end
        lo_nxt = lo_v;
        hi_nxt = hi_v;
        if ((hi_v - lo_v) > CNT_W'(1)) begin
          mid_v     = lo_v + ((hi_v - lo_v) >> 1);
          mid_nxt   = mid_v;
          idx_v     = mid_v - CNT_W'(1);
          mem_raddr = idx_v[AW-1:0];
        end else begin
          mem_raddr = lo_v[AW-1:0];
          state_nxt = S_HI;
        end
      end
      S_HI: begin
        res_nxt                = '0;
        res_nxt.status         = ST_OK;
        res_nxt.found_symbol   = find_r ? SYM_W'(lo_r) : '0;
        res_nxt.range_low      = VAL_W'(lo_val_r);
        res_nxt.range_high     = VAL_W'(mem_rdata);
        res_nxt.total_count    = VAL_W'(total_r);
        res_nxt.alphabet_count = ALPH_W'(model_size_r);
        state_nxt              = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      model_size_r  <= '0;
      total_r       <= '0;
      load_cnt_r    <= '0;
      load_sum_r    <= '0;
      load_active_r <= 1'b0;
      load_bad_r    <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      model_size_r  <= model_size_nxt;
      total_r       <= total_nxt;
      load_cnt_r    <= load_cnt_nxt;
      load_sum_r    <= load_sum_nxt;
      load_active_r <= load_active_nxt;
      load_bad_r    <= load_bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    lo_val_r <= lo_val_nxt;
    find_r   <= find_nxt;
    target_r <= target_nxt;
    res_r    <= res_nxt;
  end

endmodule

/* hdl/cumulative_frequency_model.sv */
// ---------------------------------------------------------------------------
// Cumulative frequency model
// Static symbol model for a range coder: load, range and find operations.
// ---------------------------------------------------------------------------
// Input beats carry the operation in in_tuser and the payload in in_tdata;
// in_tlast marks the final frequency of a load. Each input beat yields
// exactly one output beat: status in out_tuser, bounds and totals in
// out_tdata.
// One item is in work at a time; the cumulative table is a single-port-read
// memory with registered read data.
// A load beat, rejected query or unknown operation goes straight to its
// result; a range query reads the low bound (skipped for symbol 0) and then
// the high bound; a find query searches the table, then reads the high bound.
// The search steps one table read per halving of the interval.
// out_tvalid is driven from an output register that takes the result; that register
// lets the block take the next beat while a result waits.
// Reset empties the model and clears any load in progress; the table needs
// no clearing pass. While out_tready is low the result is held and the
// block stops after forming at most one further result.
// ---------------------------------------------------------------------------
`include "cumulative_frequency_model_macros.svh"

module cumulative_frequency_model #(
  parameter int MAX_SYMBOLS = cfm_pkg::MAX_SYMBOLS_DEF,
  parameter int MAX_TOTAL   = cfm_pkg::MAX_TOTAL_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // freq[16:0], symbol[24:17], target[41:25], zero fill
  input  logic [cfm_pkg::IN_DATA_W-1:0]     in_tdata,
  // operation[1:0]
  input  logic [cfm_pkg::OP_W-1:0]          in_tuser,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // found_symbol[7:0], range_low[24:8], range_high[41:25],
  // total_count[58:42], alphabet_count[67:59], zero fill
  output logic [cfm_pkg::OUT_DATA_W-1:0]    out_tdata,
  // status[1:0]
  output logic [cfm_pkg::STAT_W-1:0]        out_tuser
);

  import cfm_pkg::*;

  localparam int AW    = $clog2(MAX_SYMBOLS);
  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int SUM_W = $clog2(MAX_TOTAL + 1);

  logic             res_valid;
  logic             res_ready;
  cfm_res_t         res;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [SUM_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [SUM_W-1:0] mem_rdata;
  logic             out_valid_r;
  cfm_res_t         out_res_r;

  cfm_ctrl #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .MAX_TOTAL   (MAX_TOTAL),
    .AW          (AW),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_operation (in_tuser),
    .in_freq      (in_tdata[16:0]),
    .in_last      (in_tlast),
    .in_symbol    (in_tdata[24:17]),
    .in_target    (in_tdata[41:25]),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  cfm_table #(
    .DEPTH (MAX_SYMBOLS),
    .AW    (AW),
    .DW    (SUM_W)
  ) u_table (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {4'b0000, out_res_r.alphabet_count, out_res_r.total_count,
                       out_res_r.range_high, out_res_r.range_low,
                       out_res_r.found_symbol};

  `CFM_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready,
    "sequencer took a second beat in the cycle after an accept")
  `CFM_ASSERT_NOW(a_reject_zero, out_valid_r && (out_res_r.status == ST_REJECT),
    out_tdata == '0, "rejected load returned non-zero fields")
  `CFM_ASSERT_NOW(a_range_order, out_valid_r && (out_res_r.status == ST_OK),
    out_res_r.range_low <= out_res_r.range_high, "range low above range high")

endmodule

/* bench/cumulative_frequency_model_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cumulative frequency model - testbench
// Loads symbol models, good and broken, and queries them with range and find
// beats under random stalls on both channels. Every output beat is checked
// field by field against a predictor kept inside the bench.
// ---------------------------------------------------------------------------
module cumulative_frequency_model_test;
  import cfm_pkg::*;

  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
  localparam int SYMBOLS       = MAX_SYMBOLS_DEF;
  localparam int TOTAL_CAP     = MAX_TOTAL_DEF;
  localparam int RANDOM_ITEMS  = 1150;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 20;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]       in_tuser   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;

  logic [VAL_W-1:0] cum_counts [SYMBOLS];
  int  model_symbols = 0;
  int  load_symbols  = 0;
  int  load_running  = 0;
  bit  loading       = 1'b0;
  bit  load_broken   = 1'b0;

  cfm_res_t expected_results [$];
  int  failures      = 0;
  int  sent_items    = 0;
  int  loads_kept    = 0;
  int  loads_refused = 0;
  int  range_hits    = 0;
  int  find_hits     = 0;
  int  query_errors  = 0;
  int  quiet_cycles  = 0;
  bit  no_gaps       = 1'b0;

  cumulative_frequency_model dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial forever #5 clk = ~clk;

  function automatic logic [VAL_W-1:0] current_total();
    return (model_symbols == 0) ? '0 : cum_counts[model_symbols-1];
  endfunction

  function automatic logic [VAL_W-1:0] low_bound(int s);
    return (s == 0) ? '0 : cum_counts[s-1];
  endfunction

  function automatic cfm_res_t predict_result(logic [OP_W-1:0] op, logic [FREQ_W-1:0] freq,
      logic last, logic [SYM_W-1:0] sym, logic [TARGET_W-1:0] target);
    cfm_res_t r;
    logic [VAL_W-1:0] total;
    int found;
    r = '0;
    found = 0;
    if (op == OP_LOAD) begin
      if (!loading) begin
        model_symbols = 0;
        load_symbols  = 0;
        load_running  = 0;
        load_broken   = 1'b0;
        loading       = 1'b1;
      end
      if (!load_broken) begin
        if (load_symbols >= SYMBOLS) begin
          load_broken = 1'b1;
        end else begin
          load_running += freq;
          if (load_running > TOTAL_CAP) begin
            load_broken = 1'b1;
          end else begin
            cum_counts[load_symbols] = VAL_W'(load_running);
            load_symbols++;
          end
        end
      end
      if (last) begin
        loading = 1'b0;
        if (load_broken || load_running == 0 || load_symbols == 0) begin
          r.status = ST_REJECT;
        end else begin
          model_symbols    = load_symbols;
          r.total_count    = current_total();
          r.alphabet_count = ALPH_W'(model_symbols);
        end
      end
      return r;
    end
    total            = current_total();
    r.total_count    = total;
    r.alphabet_count = ALPH_W'(model_symbols);
    r.status         = ST_QUERY_ERR;
    if (op == OP_RANGE && sym < model_symbols) begin
      r.status     = ST_OK;
      r.range_low  = low_bound(int'(sym));
      r.range_high = cum_counts[sym];
    end else if (op == OP_FIND && target < total) begin
      r.status = ST_OK;
      for (int s = 0; s < model_symbols; s++) begin
        if (low_bound(s) <= target) found = s;
      end
      r.found_symbol = SYM_W'(found);
      r.range_low    = low_bound(found);
      r.range_high   = cum_counts[found];
    end
    return r;
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, logic [FREQ_W-1:0] freq, logic last,
      logic [SYM_W-1:0] sym, logic [TARGET_W-1:0] target);
    cfm_res_t r;
    while (!no_gaps && $urandom_range(0, 99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tlast  <= last;
    in_tdata  <= {{(IN_DATA_W - FREQ_W - SYM_W - TARGET_W){1'b0}}, target, sym, freq};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = predict_result(op, freq, last, sym, target);
    expected_results.push_back(r);
    sent_items++;
    if (op == OP_LOAD) begin
      if (last && r.status == ST_OK) loads_kept++;
      else if (last) loads_refused++;
    end else if (r.status != ST_OK) begin
      query_errors++;
    end else if (op == OP_RANGE) begin
      range_hits++;
    end else begin
      find_hits++;
    end
  endtask

  task automatic send_load(int freq, logic last);
    send_item(OP_LOAD, FREQ_W'(freq), last, SYM_W'($urandom_range(0, 255)),
              TARGET_W'($urandom_range(0, TOTAL_CAP)));
  endtask

  task automatic send_range(int sym);
    send_item(OP_RANGE, FREQ_W'($urandom_range(0, TOTAL_CAP)), 1'($urandom_range(0, 1)),
              SYM_W'(sym), TARGET_W'($urandom_range(0, TOTAL_CAP)));
  endtask

  task automatic send_find(int target);
    send_item(OP_FIND, FREQ_W'($urandom_range(0, TOTAL_CAP)), 1'($urandom_range(0, 1)),
              SYM_W'($urandom_range(0, 255)), TARGET_W'(target));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : check_results
    cfm_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("output beat with no item outstanding");
        failures++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", VAL_W'(want.status), VAL_W'(out_tuser));
        check_field("found_symbol", VAL_W'(want.found_symbol), VAL_W'(out_tdata[7:0]));
        check_field("range_low", want.range_low, out_tdata[24:8]);
        check_field("range_high", want.range_high, out_tdata[41:25]);
        check_field("total_count", want.total_count, out_tdata[58:42]);
        check_field("alphabet_count", VAL_W'(want.alphabet_count),
                    VAL_W'(out_tdata[67:59]));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no beat moved for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial forever begin
    @(posedge clk);
    out_tready <= no_gaps || ($urandom_range(0, 99) >= 8);
  end

  task automatic test_empty_model();
    send_range(0);
    send_range(255);
    send_find(0);
    send_find(TOTAL_CAP);
    send_item(OP_UNKNOWN, FREQ_W'(TOTAL_CAP), 1'b1, 8'hFF, TARGET_W'(TOTAL_CAP));
    wait_drained();
  endtask

  task automatic test_single_symbol();
    send_load(TOTAL_CAP, 1'b1);
    send_range(0);
    send_range(1);
    send_range(255);
    send_find(0);
    send_find(TOTAL_CAP - 1);
    send_find(TOTAL_CAP);
    send_item(OP_UNKNOWN, '0, 1'b0, '0, '0);
    wait_drained();
  endtask

  task automatic test_load_rejects();
    send_load(0, 1'b1);
    send_load(TOTAL_CAP, 1'b0);
    send_load(1, 1'b1);
    send_load(5, 1'b0);
    send_range(0);
    send_find(2);
    send_load(0, 1'b0);
    send_load(7, 1'b1);
    send_find(4);
    send_find(5);
    send_range(1);
    send_find(11);
    send_load(TOTAL_CAP - 1, 1'b0);
    send_load(1, 1'b1);
    send_find(TOTAL_CAP - 1);
    wait_drained();
  endtask

  task automatic test_too_many_symbols();
    for (int i = 0; i <= SYMBOLS; i++) send_load(1, i == SYMBOLS);
    send_range(0);
    for (int i = 0; i < SYMBOLS; i++) send_load(TOTAL_CAP / SYMBOLS, i == SYMBOLS - 1);
    send_range(SYMBOLS - 1);
    send_find(0);
    send_find(TOTAL_CAP / 2);
    send_find(TOTAL_CAP - 1);
    wait_drained();
  endtask

  task automatic load_model(int count, int ceiling);
    int fmax;
    int left;
    int f;
    case ($urandom_range(0, 3))
      0:       fmax = 8;
      1:       fmax = 300;
      2:       fmax = 5000;
      default: fmax = TOTAL_CAP;
    endcase
    left = ceiling;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) == 0) send_range($urandom_range(0, 255));
        else send_find($urandom_range(0, TOTAL_CAP));
      end
      f = $urandom_range(0, (fmax < left) ? fmax : left);
      if ($urandom_range(0, 9) == 0) f = 0;
      if (i == count - 1 && ceiling == TOTAL_CAP && $urandom_range(0, 3) == 0) f = left;
      if (f > TOTAL_CAP) f = TOTAL_CAP;
      left -= f;
      send_load(f, i == count - 1);
    end
  endtask

  task automatic query_model(int count);
    int total;
    for (int i = 0; i < count; i++) begin
      total = int'(current_total());
      case ($urandom_range(0, 9))
        0, 1, 2, 3:
          send_range((model_symbols > 0) ? $urandom_range(0, model_symbols - 1)
                                         : $urandom_range(0, 255));
        4, 5, 6, 7:
          send_find((total > 0) ? $urandom_range(0, total - 1)
                                : $urandom_range(0, TOTAL_CAP));
        8:       send_range($urandom_range(0, 255));
        default: send_find($urandom_range(0, TOTAL_CAP));
      endcase
    end
  endtask

  task automatic test_random_traffic();
    int start;
    int pick;
    int count;
    bit paused;
    start  = sent_items;
    paused = 1'b0;
    while (sent_items < start + RANDOM_ITEMS) begin
      no_gaps = (sent_items - start >= 600) && (sent_items - start < 900);
      if (!paused && sent_items - start > RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 80) count = $urandom_range(1, 12);
      else if ($urandom_range(0, 99) < 75) count = $urandom_range(13, 64);
      else count = $urandom_range(65, SYMBOLS);
      if (pick < 70) begin
        load_model(count, TOTAL_CAP);
      end else if (pick < 80) begin
        load_model(count, 4 * TOTAL_CAP);
      end else if (pick < 85) begin
        for (int i = 0; i < 4; i++) send_load(0, i == 3);
      end else begin
        for (int i = $urandom_range(1, 6); i > 0; i--) begin
          send_item(OP_W'($urandom_range(0, 3)), FREQ_W'($urandom_range(0, TOTAL_CAP)),
                    1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 255)),
                    TARGET_W'($urandom_range(0, TOTAL_CAP)));
        end
      end
      query_model($urandom_range(3, 12));
    end
    no_gaps = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_model();
    test_single_symbol();
    test_load_rejects();
    test_too_many_symbols();
    test_random_traffic();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d beats sent: %0d models taken, %0d loads refused",
             sent_items, loads_kept, loads_refused);
    $display("%0d range and %0d find queries answered, %0d queries refused",
             range_hits, find_hits, query_errors);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/cfm_pkg.sv
hdl/cfm_table.sv
hdl/cfm_ctrl.sv
hdl/cumulative_frequency_model.sv
bench/cumulative_frequency_model_test.sv
